/* design/wbie_pkg.sv */
// shared constants and types for the wah bitmap index encoder
`default_nettype none

package wbie_pkg;

    localparam int ROW_ID_BITS_DEF = 24;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int CHUNK_SIZE      = 31;
    localparam int INDEX_WORD_BITS = 32;
    localparam int MAX_WORDS       = 4;
    localparam int WORD_CNT_BITS   = $clog2(MAX_WORDS + 1);
    localparam int WORD_IDX_BITS   = $clog2(MAX_WORDS);
    localparam int BIT_IDX_BITS    = 5;
    localparam int REM_BITS        = 6;

    // floor(2^32 / 31)
    localparam logic [31:0] RECIP_31 = 32'h0842_1084;

    localparam logic LITERAL_FLAG = 1'b1;

    localparam int SLOT_FILL_CLOSE = 0;
    localparam int SLOT_LIT_CLOSE  = 1;
    localparam int SLOT_FILL_FLUSH = 2;
    localparam int SLOT_LIT_FLUSH  = 3;

    typedef struct packed {
        logic is_fill;
        logic order_error;
        logic run_end;
        logic index_end;
    } word_flags_t;

endpackage

`default_nettype wire

/* design/wbie_chunk_split.sv */
// input register stage with row id split into chunk number and bit position
`default_nettype none

module wbie_chunk_split #(
    parameter int VALUE_BITS  = wbie_pkg::VALUE_BITS_DEF,
    parameter int ROW_ID_BITS = wbie_pkg::ROW_ID_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [VALUE_BITS-1:0]               key_value,
    input  wire logic [ROW_ID_BITS-1:0]              row_id,
    input  wire logic                                final_pair,
    input  wire logic                                advance,
    output logic                                     s1_valid,
    output logic [VALUE_BITS-1:0]                    s1_value,
    output logic [ROW_ID_BITS-1:0]                   s1_row,
    output logic [ROW_ID_BITS-5:0]                   s1_chunk,
    output logic [wbie_pkg::BIT_IDX_BITS-1:0]        s1_bit,
    output logic                                     s1_final
);
    import wbie_pkg::*;

    localparam int CHUNK_W = ROW_ID_BITS - 4;
    localparam int PROD_W  = ROW_ID_BITS + 32;

    logic                     valid_reg;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [ROW_ID_BITS-1:0]   row_reg;
    logic [CHUNK_W-1:0]       chunk_reg;
    logic [BIT_IDX_BITS-1:0]  bit_reg;
    logic                     final_reg;

    logic [PROD_W-1:0]        prod;
    logic [CHUNK_W-1:0]       q_est;
    logic [REM_BITS-1:0]      x6;
    logic [REM_BITS-1:0]      q6;
    logic [REM_BITS-1:0]      t6;
    logic [REM_BITS-1:0]      rem6;
    logic [CHUNK_W-1:0]       chunk_calc;
    logic [BIT_IDX_BITS-1:0]  bit_calc;
    logic                     take;

    assign take     = in_valid && in_ready;
    assign in_ready = !valid_reg || advance;

    // reciprocal estimate is at most one low, fixed by one compare
    always_comb
    begin
        prod  = PROD_W'(row_id) * PROD_W'(RECIP_31);
        q_est = prod[CHUNK_W+31:32];
        x6    = REM_BITS'(row_id);
        q6    = REM_BITS'(q_est);
        t6    = {q6[0], 5'b0} - q6;
        rem6  = x6 - t6;
        if (rem6 >= REM_BITS'(CHUNK_SIZE))
        begin
            chunk_calc = q_est + CHUNK_W'(1);
            bit_calc   = BIT_IDX_BITS'(rem6 - REM_BITS'(CHUNK_SIZE));
        end
        else
        begin
            chunk_calc = q_est;
            bit_calc   = rem6[BIT_IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= key_value;
            row_reg   <= row_id;
            chunk_reg <= chunk_calc;
            bit_reg   <= bit_calc;
            final_reg <= final_pair;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_value = value_reg;
    assign s1_row   = row_reg;
    assign s1_chunk = chunk_reg;
    assign s1_bit   = bit_reg;
    assign s1_final = final_reg;

endmodule

`default_nettype wire

/* design/wbie_group_merge.sv */
// group merge state and construction of the words caused by one pair
`default_nettype none

module wbie_group_merge #(
    parameter int VALUE_BITS  = wbie_pkg::VALUE_BITS_DEF,
    parameter int ROW_ID_BITS = wbie_pkg::ROW_ID_BITS_DEF
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               advance,
    input  wire logic [VALUE_BITS-1:0]                              s1_value,
    input  wire logic [ROW_ID_BITS-1:0]                             s1_row,
    input  wire logic [ROW_ID_BITS-5:0]                             s1_chunk,
    input  wire logic [wbie_pkg::BIT_IDX_BITS-1:0]                  s1_bit,
    input  wire logic                                               s1_final,
    output logic [wbie_pkg::MAX_WORDS-1:0][wbie_pkg::INDEX_WORD_BITS-1:0] bundle_words,
    output logic [wbie_pkg::MAX_WORDS-1:0][VALUE_BITS-1:0]          bundle_values,
    output wbie_pkg::word_flags_t [wbie_pkg::MAX_WORDS-1:0]         bundle_flags,
    output logic [wbie_pkg::WORD_CNT_BITS-1:0]                      bundle_cnt
);
    import wbie_pkg::*;

    localparam int CHUNK_W = ROW_ID_BITS - 4;
    localparam int LIT_W   = CHUNK_SIZE;

    logic [VALUE_BITS-1:0]    last_value_reg;
    logic [ROW_ID_BITS-1:0]   last_row_reg;
    logic [CHUNK_W-1:0]       group_chunk_reg;
    logic [LIT_W-1:0]         group_bits_reg;
    logic                     group_open_reg;
    logic [CHUNK_W-1:0]       prior_chunk_reg;
    logic                     prior_in_value_reg;

    logic                     group_open_next;
    logic                     prior_in_value_next;
    logic [LIT_W-1:0]         group_bits_next;
    logic [CHUNK_W-1:0]       prior_chunk_next;

    logic                     order_err;
    logic                     same_value;
    logic                     close_one;
    logic [CHUNK_W-1:0]       skip_one;
    logic [CHUNK_W-1:0]       skip_two;
    logic [CHUNK_W-1:0]       prior_chunk_mid;
    logic                     prior_in_mid;
    logic [LIT_W-1:0]         bit_mask;
    logic [LIT_W-1:0]         bits_mid;

    logic [MAX_WORDS-1:0][INDEX_WORD_BITS-1:0] cand_words;
    logic [MAX_WORDS-1:0][VALUE_BITS-1:0]      cand_values;
    word_flags_t [MAX_WORDS-1:0]               cand_flags;
    logic [MAX_WORDS-1:0]                      cand_en;

    always_comb
    begin
        order_err  = group_open_reg && ((s1_value < last_value_reg) ||
                     ((s1_value == last_value_reg) && (s1_row < last_row_reg)));
        same_value = (s1_value == last_value_reg);
        close_one  = group_open_reg && (!same_value || (s1_chunk != group_chunk_reg));
        skip_one   = prior_in_value_reg ? (group_chunk_reg - prior_chunk_reg - CHUNK_W'(1))
                                        : group_chunk_reg;
        prior_chunk_mid = close_one ? group_chunk_reg : prior_chunk_reg;
        prior_in_mid    = close_one ? same_value : prior_in_value_reg;
        bit_mask   = LIT_W'(1) << s1_bit;
        bits_mid   = (group_open_reg && !close_one) ? (group_bits_reg | bit_mask) : bit_mask;
        skip_two   = prior_in_mid ? (s1_chunk - prior_chunk_mid - CHUNK_W'(1)) : s1_chunk;

        cand_words  = '0;
        cand_values = '0;
        cand_flags  = '0;

        cand_words[SLOT_FILL_CLOSE]          = INDEX_WORD_BITS'(skip_one);
        cand_values[SLOT_FILL_CLOSE]         = last_value_reg;
        cand_flags[SLOT_FILL_CLOSE].is_fill  = 1'b1;
        cand_en[SLOT_FILL_CLOSE]             = close_one && (skip_one != '0);

        cand_words[SLOT_LIT_CLOSE]           = {LITERAL_FLAG, group_bits_reg};
        cand_values[SLOT_LIT_CLOSE]          = last_value_reg;
        cand_en[SLOT_LIT_CLOSE]              = close_one;

        cand_words[SLOT_FILL_FLUSH]          = INDEX_WORD_BITS'(skip_two);
        cand_values[SLOT_FILL_FLUSH]         = s1_value;
        cand_flags[SLOT_FILL_FLUSH].is_fill  = 1'b1;
        cand_en[SLOT_FILL_FLUSH]             = s1_final && (skip_two != '0);

        cand_words[SLOT_LIT_FLUSH]           = {LITERAL_FLAG, bits_mid};
        cand_values[SLOT_LIT_FLUSH]          = s1_value;
        cand_flags[SLOT_LIT_FLUSH].index_end = 1'b1;
        cand_en[SLOT_LIT_FLUSH]              = s1_final;
    end

    // pack enabled words to the front, mark the last one; an out-of-order pair gives one order_error word
    always_comb
    begin
        logic [WORD_CNT_BITS-1:0] n;
        logic [WORD_CNT_BITS-1:0] last;
        bundle_words  = '0;
        bundle_values = '0;
        bundle_flags  = '0;
        n             = '0;
        last          = '0;
        if (order_err)
        begin
            bundle_flags[0].order_error = 1'b1;
            bundle_flags[0].run_end     = 1'b1;
            n                           = WORD_CNT_BITS'(1);
        end
        else
        begin
            for (int i = 0; i < MAX_WORDS; i++)
            begin
                if (cand_en[i])
                begin
                    bundle_words[n[WORD_IDX_BITS-1:0]]  = cand_words[i];
                    bundle_values[n[WORD_IDX_BITS-1:0]] = cand_values[i];
                    bundle_flags[n[WORD_IDX_BITS-1:0]]  = cand_flags[i];
                    n = n + WORD_CNT_BITS'(1);
                end
            end
            if (n != '0)
            begin
                last = n - WORD_CNT_BITS'(1);
                bundle_flags[last[WORD_IDX_BITS-1:0]].run_end = 1'b1;
            end
        end
        bundle_cnt = n;
    end

    always_comb
    begin
        group_open_next     = group_open_reg;
        prior_in_value_next = prior_in_value_reg;
        if (advance && !order_err)
        begin
            group_open_next     = !s1_final;
            prior_in_value_next = s1_final ? 1'b0 : prior_in_mid;
        end
        group_bits_next  = bits_mid;
        prior_chunk_next = prior_chunk_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_open_reg     <= 1'b0;
            prior_in_value_reg <= 1'b0;
        end
        else
        begin
            group_open_reg     <= group_open_next;
            prior_in_value_reg <= prior_in_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !order_err)
        begin
            last_value_reg  <= s1_value;
            last_row_reg    <= s1_row;
            group_chunk_reg <= s1_chunk;
            group_bits_reg  <= group_bits_next;
            prior_chunk_reg <= prior_chunk_next;
        end
    end

endmodule

`default_nettype wire

/* design/wbie_word_queue.sv */
// result register that holds the words of one pair and sends them one at a time
`default_nettype none

module wbie_word_queue #(
    parameter int VALUE_BITS = wbie_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               advance,
    input  wire logic [wbie_pkg::MAX_WORDS-1:0][wbie_pkg::INDEX_WORD_BITS-1:0] load_words,
    input  wire logic [wbie_pkg::MAX_WORDS-1:0][VALUE_BITS-1:0]     load_values,
    input  wire wbie_pkg::word_flags_t [wbie_pkg::MAX_WORDS-1:0]    load_flags,
    input  wire logic [wbie_pkg::WORD_CNT_BITS-1:0]                 load_cnt,
    output logic                                                    free,
    output logic                                                    out_valid,
    input  wire logic                                               out_ready,
    output logic [wbie_pkg::INDEX_WORD_BITS-1:0]                    index_word,
    output logic [VALUE_BITS-1:0]                                   word_value,
    output logic                                                    is_fill,
    output logic                                                    order_error,
    output logic                                                    run_end,
    output logic                                                    index_end
);
    import wbie_pkg::*;

    logic [WORD_CNT_BITS-1:0]                  cnt_reg;
    logic [WORD_CNT_BITS-1:0]                  cnt_next;
    logic [MAX_WORDS-1:0][INDEX_WORD_BITS-1:0] words_reg;
    logic [MAX_WORDS-1:0][INDEX_WORD_BITS-1:0] words_next;
    logic [MAX_WORDS-1:0][VALUE_BITS-1:0]      values_reg;
    logic [MAX_WORDS-1:0][VALUE_BITS-1:0]      values_next;
    word_flags_t [MAX_WORDS-1:0]               flags_reg;
    word_flags_t [MAX_WORDS-1:0]               flags_next;
    logic                                      send;

    assign out_valid = (cnt_reg != '0);
    assign send      = out_valid && out_ready;
    assign free      = (cnt_reg == '0) ||
                       ((cnt_reg == WORD_CNT_BITS'(1)) && out_ready);

    always_comb
    begin
        cnt_next    = cnt_reg;
        words_next  = words_reg;
        values_next = values_reg;
        flags_next  = flags_reg;
        if (advance)
        begin
            cnt_next    = load_cnt;
            words_next  = load_words;
            values_next = load_values;
            flags_next  = load_flags;
        end
        else if (send)
        begin
            cnt_next = cnt_reg - WORD_CNT_BITS'(1);
            for (int i = 0; i < MAX_WORDS - 1; i++)
            begin
                words_next[i]  = words_reg[i+1];
                values_next[i] = values_reg[i+1];
                flags_next[i]  = flags_reg[i+1];
            end
            words_next[MAX_WORDS-1]  = '0;
            values_next[MAX_WORDS-1] = '0;
            flags_next[MAX_WORDS-1]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg  <= words_next;
        values_reg <= values_next;
        flags_reg  <= flags_next;
    end

    assign index_word  = words_reg[0];
    assign word_value  = values_reg[0];
    assign is_fill     = flags_reg[0].is_fill;
    assign order_error = flags_reg[0].order_error;
    assign run_end     = flags_reg[0].run_end;
    assign index_end   = flags_reg[0].index_end;

endmodule

`default_nettype wire

/* design/wah_bitmap_index_encoder.sv */
// wah bitmap index encoder: sorted (value, row id) pairs in, 32-bit wah index words out
//
// input channel: in_valid/in_ready carry one word of key_value, row_id, final_pair.
// pairs must arrive sorted by value, then by row id; an out-of-order pair is
// dropped and answered by one word with order_error and run_end set.
// output channel: out_valid/out_ready carry one index word at a time with its
// word_value and flags; run_end marks the last word a pair caused and
// index_end the last literal of the whole index after a final pair.
// a pair taken is held in the input register, then its words are built and loaded into
// the result register once that is free; the first word is presented from there.
// throughput: one pair per cycle while each pair gives at most one word and out_ready
// is high; a pair that gives more than one word (up to 4) stalls the input until the
// single output port has drained the result register, one word per cycle while out_ready is high.
// the input register and the result register sit between the two sides, so
// a new pair is taken while the last word of the previous one waits.
// when the receiver stalls, words hold and the input backs up after one pair.
// reset clears the pending group and empties both registers; a final pair
// clears the pending group again once its words are built.
`default_nettype none

module wah_bitmap_index_encoder #(
    parameter int VALUE_BITS  = wbie_pkg::VALUE_BITS_DEF,
    parameter int ROW_ID_BITS = wbie_pkg::ROW_ID_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [VALUE_BITS-1:0]               key_value,
    input  wire logic [ROW_ID_BITS-1:0]              row_id,
    input  wire logic                                final_pair,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [wbie_pkg::INDEX_WORD_BITS-1:0]     index_word,
    output logic [VALUE_BITS-1:0]                    word_value,
    output logic                                     is_fill,
    output logic                                     order_error,
    output logic                                     run_end,
    output logic                                     index_end
);
    import wbie_pkg::*;

    localparam int CHUNK_W = ROW_ID_BITS - 4;

    logic                                      s1_valid;
    logic [VALUE_BITS-1:0]                     s1_value;
    logic [ROW_ID_BITS-1:0]                    s1_row;
    logic [CHUNK_W-1:0]                        s1_chunk;
    logic [BIT_IDX_BITS-1:0]                   s1_bit;
    logic                                      s1_final;
    logic                                      queue_free;
    logic                                      advance;

    logic [MAX_WORDS-1:0][INDEX_WORD_BITS-1:0] bundle_words;
    logic [MAX_WORDS-1:0][VALUE_BITS-1:0]      bundle_values;
    word_flags_t [MAX_WORDS-1:0]               bundle_flags;
    logic [WORD_CNT_BITS-1:0]                  bundle_cnt;

    assign advance = s1_valid && queue_free;

    wbie_chunk_split #(
        .VALUE_BITS  (VALUE_BITS),
        .ROW_ID_BITS (ROW_ID_BITS)
    ) u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_value  (key_value),
        .row_id     (row_id),
        .final_pair (final_pair),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_value   (s1_value),
        .s1_row     (s1_row),
        .s1_chunk   (s1_chunk),
        .s1_bit     (s1_bit),
        .s1_final   (s1_final)
    );

    wbie_group_merge #(
        .VALUE_BITS  (VALUE_BITS),
        .ROW_ID_BITS (ROW_ID_BITS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .s1_value      (s1_value),
        .s1_row        (s1_row),
        .s1_chunk      (s1_chunk),
        .s1_bit        (s1_bit),
        .s1_final      (s1_final),
        .bundle_words  (bundle_words),
        .bundle_values (bundle_values),
        .bundle_flags  (bundle_flags),
        .bundle_cnt    (bundle_cnt)
    );

    wbie_word_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .load_words  (bundle_words),
        .load_values (bundle_values),
        .load_flags  (bundle_flags),
        .load_cnt    (bundle_cnt),
        .free        (queue_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .index_word  (index_word),
        .word_value  (word_value),
        .is_fill     (is_fill),
        .order_error (order_error),
        .run_end     (run_end),
        .index_end   (index_end)
    );

endmodule

`default_nettype wire
